/* hw/rtl/fsoa_pkg.sv */
package fsoa_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_SLOTS   = 64;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 12;
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int CNT_W  = $clog2(NUM_CLASSES + 1);
    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int PROD_W = SLOT_W + SIZE_W;
    localparam int DIV_W  = (PAGE_W > SIZE_W) ? PAGE_W : SIZE_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_POOL_BASE = 1'b0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DOUBLE    = 2'd2;
    localparam logic [1:0] ST_NOT_OWNED = 2'd3;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] obj_addr;
        logic [1:0]        status;
    } t_res;

endpackage

/* hw/rtl/fsoa_div.sv */
module fsoa_div
    import fsoa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_act;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_quot;
    logic [DIV_W-1:0]  r_divisor;

    logic [DIV_W:0]    rem_sh;
    logic              fits;

    // Restoring division: one quotient bit per cycle, dividend bits shift out of r_quot.
    assign rem_sh = {r_rem[DIV_W-1:0], r_quot[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act     <= 1'b1;
                r_cnt     <= STEP_W'(DIV_W - 1);
                r_rem     <= '0;
                r_quot    <= i_dividend;
                r_divisor <= i_divisor;
            end else if (r_act) begin
                r_rem  <= fits ? (rem_sh - {1'b0, r_divisor}) : rem_sh;
                r_quot <= {r_quot[DIV_W-2:0], fits};
                if (r_cnt == '0) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hw/rtl/fixed_size_object_allocator.sv */
// Channel   | Direction | Signals                           | Handshake
// request   | in        | i_req (func, req_size, free_addr) | start & !busy
// result    | out       | o_res (obj_addr, status)          | o_done, one cycle
// config    | in        | psel penable pwrite paddr pwdata  | APB write, pready = 1
//
// An allocate steps through S_FIND over the registered classes, S_PICK, S_MUL
// and S_CHECK; an allocate of zero size is answered from idle. A free steps
// through S_OWN over the class pages, S_DIV with the 12-step slot divider,
// S_MUL and S_CHECK.
// One item is in flight at a time: busy is high from accept until o_done shows,
// except for a zero-size allocate. Results cannot be stalled by the receiver.
// Reset clears the class count, all slot bitmaps and pool_base.
module fixed_size_object_allocator
    import fsoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_done,
    output t_res               o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_PICK,
        S_OWN,
        S_DIV,
        S_MUL,
        S_CHECK
    } t_state;

    t_state              r_state;
    logic                r_func;
    logic [SIZE_W-1:0]   r_size;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_page;
    logic [CNT_W-1:0]    r_k;
    logic [SLOT_W-1:0]   r_slot;
    logic [PROD_W-1:0]   r_prod;
    logic                r_done;
    t_res                r_res;
    logic [ADDR_W-1:0]   r_base;
    logic [CNT_W-1:0]    r_class_count;
    logic [MAX_SLOTS-1:0] r_bitmap [NUM_CLASSES];
    logic [SIZE_W-1:0]   r_class_size [NUM_CLASSES];
    logic                r_div_start;
    logic [DIV_W-1:0]    r_dividend;

    logic [CLS_W-1:0]     k_idx;
    logic [MAX_SLOTS-1:0] cur_bm;
    logic [SIZE_W-1:0]    cur_size;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    logic [ADDR_W-1:0]    page_off;
    logic [PROD_W:0]      slot_end;
    logic                 slot_fits;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quot;
    logic                 cfg_wr;
    logic                 reg_new;

    assign k_idx    = r_k[CLS_W-1:0];
    assign cur_bm   = r_bitmap[k_idx];
    assign cur_size = r_class_size[k_idx];
    assign page_off = r_addr - r_page;

    // The slot exists only if it ends inside the page.
    assign slot_end  = {1'b0, r_prod} + (PROD_W + 1)'(r_size);
    assign slot_fits = slot_end <= (PROD_W + 1)'(PAGE_BYTES);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
            if (!cur_bm[j]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(j);
            end
        end
    end

    assign reg_new = (r_state == S_FIND) && (r_k >= r_class_count)
                     && (r_class_count < CNT_W'(NUM_CLASSES));

    fsoa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (DIV_W'(r_size)),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_POOL_BASE) ? r_base : '0;

    always_ff @(posedge i_clk) begin
        if (reg_new) begin
            r_class_size[r_class_count[CLS_W-1:0]] <= r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_done        <= 1'b0;
            r_div_start   <= 1'b0;
            r_base        <= '0;
            r_class_count <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_bitmap[c] <= '0;
            end
        end else begin
            r_done      <= 1'b0;
            r_div_start <= 1'b0;
            if (cfg_wr && (paddr[PADDR_W-1] == REG_POOL_BASE)) begin
                r_base <= pwdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func <= i_req.func;
                        r_size <= i_req.req_size;
                        r_addr <= i_req.free_addr;
                        r_k    <= '0;
                        r_page <= r_base;
                        if (i_req.func == FUNC_FREE) begin
                            r_state <= S_OWN;
                        end else if (i_req.req_size == '0) begin
                            r_done  <= 1'b1;
                            r_res   <= '{obj_addr: '0, status: ST_FULL};
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (r_k >= r_class_count) begin
                        if (reg_new) begin
                            r_bitmap[k_idx] <= '0;
                            r_class_count   <= r_class_count + 1'b1;
                            r_state         <= S_PICK;
                        end else begin
                            r_done  <= 1'b1;
                            r_res   <= '{obj_addr: '0, status: ST_FULL};
                            r_state <= S_IDLE;
                        end
                    end else if (cur_size == r_size) begin
                        r_state <= S_PICK;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_PICK: begin
                    if (free_found) begin
                        r_slot  <= free_idx;
                        r_state <= S_MUL;
                    end else begin
                        r_done  <= 1'b1;
                        r_res   <= '{obj_addr: '0, status: ST_FULL};
                        r_state <= S_IDLE;
                    end
                end
                S_OWN: begin
                    if (r_k >= r_class_count) begin
                        r_done  <= 1'b1;
                        r_res   <= '{obj_addr: '0, status: ST_NOT_OWNED};
                        r_state <= S_IDLE;
                    end else if (page_off[ADDR_W-1:PAGE_W] == '0) begin
                        if (cur_size == '0) begin
                            r_done  <= 1'b1;
                            r_res   <= '{obj_addr: '0, status: ST_NOT_OWNED};
                            r_state <= S_IDLE;
                        end else begin
                            r_size      <= cur_size;
                            r_dividend  <= DIV_W'(page_off[PAGE_W-1:0]);
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end else begin
                        r_k    <= r_k + 1'b1;
                        r_page <= r_page + ADDR_W'(PAGE_BYTES);
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (div_quot >= DIV_W'(MAX_SLOTS)) begin
                            r_done  <= 1'b1;
                            r_res   <= '{obj_addr: '0, status: ST_NOT_OWNED};
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= div_quot[SLOT_W-1:0];
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_slot) * PROD_W'(r_size);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_func == FUNC_ALLOC) begin
                        if (slot_fits) begin
                            r_bitmap[k_idx][r_slot] <= 1'b1;
                            // The slot offset stays below one page, so it merges with the page index.
                            r_res <= '{obj_addr: r_base + ((ADDR_W'(k_idx) << PAGE_W)
                                                 | ADDR_W'(r_prod)),
                                       status: ST_OK};
                        end else begin
                            r_res <= '{obj_addr: '0, status: ST_FULL};
                        end
                    end else begin
                        if (!slot_fits) begin
                            r_res <= '{obj_addr: '0, status: ST_NOT_OWNED};
                        end else if (!cur_bm[r_slot]) begin
                            r_res <= '{obj_addr: '0, status: ST_DOUBLE};
                        end else begin
                            r_bitmap[k_idx][r_slot] <= 1'b0;
                            r_res <= '{obj_addr: '0, status: ST_OK};
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* test/fixed_size_object_allocator_tb.sv */
`timescale 1ns / 1ps

module fixed_size_object_allocator_tb
    import fsoa_pkg::*;
();

    localparam logic [PADDR_W-1:0] POOL_BASE_ADDR = PADDR_W'({REG_POOL_BASE, 2'b00});
    localparam int PHASE_ITEMS = 120;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        t_req req;
        bit   fixed;
        t_res res;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_req               i_req;
    logic               o_done;
    t_res               o_res;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow copy of the allocator state.
    logic [ADDR_W-1:0]    pool_base;
    int unsigned          class_cnt;
    logic [SIZE_W-1:0]    class_sz [NUM_CLASSES];
    logic [MAX_SLOTS-1:0] slot_map [NUM_CLASSES];

    t_res     pending_res[$];
    t_dir_row dir_rows[$];
    bit       fixed_valid;
    t_res     fixed_res;
    t_res     predicted;
    t_res     oldest;
    int       idle_pct;
    int       err_cnt;
    int       item_cnt;
    int       alloc_cnt;
    int       free_cnt;
    int       base_cnt;
    int       status_cnt [4];

    fixed_size_object_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned slot_limit(input logic [SIZE_W-1:0] sz);
        int unsigned n;
        if (sz == 0) begin
            return 0;
        end
        n = PAGE_BYTES / sz;
        return (n > MAX_SLOTS) ? MAX_SLOTS : n;
    endfunction

    function automatic logic [ADDR_W-1:0] class_page(input int unsigned k);
        return pool_base + k * PAGE_BYTES;
    endfunction

    // Applies one request to the shadow state and returns the outcome.
    function automatic t_res serve_request(input t_req r);
        t_res              res;
        int unsigned       k;
        int unsigned       n;
        int unsigned       slot;
        logic [ADDR_W-1:0] off;
        bit                hit;
        res.obj_addr = '0;
        res.status   = ST_NOT_OWNED;
        if (r.func == FUNC_ALLOC) begin
            res.status = ST_FULL;
            if (r.req_size == 0) begin
                return res;
            end
            hit = 1'b0;
            k = 0;
            for (int i = 0; i < class_cnt; i++) begin
                if (!hit && class_sz[i] == r.req_size) begin
                    k = i;
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (class_cnt >= NUM_CLASSES) begin
                    return res;
                end
                k = class_cnt;
                class_sz[k] = r.req_size;
                slot_map[k] = '0;
                class_cnt++;
            end
            n = slot_limit(r.req_size);
            for (int i = 0; i < n; i++) begin
                if (!slot_map[k][i]) begin
                    slot_map[k][i] = 1'b1;
                    res.obj_addr = class_page(k) + i * r.req_size;
                    res.status = ST_OK;
                    return res;
                end
            end
        end else begin
            for (int i = 0; i < class_cnt; i++) begin
                off = r.free_addr - class_page(i);
                if (off < PAGE_BYTES) begin
                    slot = off / class_sz[i];
                    if (slot >= slot_limit(class_sz[i])) begin
                        res.status = ST_NOT_OWNED;
                    end else if (!slot_map[i][slot]) begin
                        res.status = ST_DOUBLE;
                    end else begin
                        slot_map[i][slot] = 1'b0;
                        res.status = ST_OK;
                    end
                    return res;
                end
            end
        end
        return res;
    endfunction

    // Mostly allocations of registered sizes and frees of live objects, the rest
    // double frees, page tails, unknown sizes and arbitrary addresses.
    function automatic t_req next_request();
        t_req              r;
        int unsigned       pick;
        int unsigned       k;
        int unsigned       n;
        int unsigned       slot;
        int unsigned       used;
        logic [SIZE_W-1:0] sz;
        r.func      = FUNC_FREE;
        r.req_size  = SIZE_W'($urandom);
        r.free_addr = $urandom;
        pick = $urandom_range(99);
        if (class_cnt == 0 || pick >= 94) begin
            r.func = ($urandom_range(1) == 0) ? FUNC_ALLOC : FUNC_FREE;
            return r;
        end
        k  = $urandom_range(class_cnt - 1);
        sz = class_sz[k];
        n  = slot_limit(sz);
        if (pick < 45) begin
            r.func = FUNC_ALLOC;
            r.req_size = sz;
        end else if (pick < 50) begin
            r.func = FUNC_ALLOC;
            r.req_size = SIZE_W'($urandom_range(0, 4095));
        end else if (pick < 88) begin
            slot = $urandom_range(n - 1);
            if (pick < 80) begin
                // Prefer a slot that is in use, starting the scan at a random point.
                for (int i = 0; i < n; i++) begin
                    if (slot_map[k][(slot + i) % n]) begin
                        slot = (slot + i) % n;
                        break;
                    end
                end
            end
            r.free_addr = class_page(k) + slot * sz + $urandom_range(sz - 1);
        end else begin
            used = n * sz;
            if (used < PAGE_BYTES) begin
                r.free_addr = class_page(k) + used + $urandom_range(PAGE_BYTES - 1 - used);
            end else begin
                r.free_addr = class_page(k) + $urandom_range(PAGE_BYTES - 1);
            end
        end
        return r;
    endfunction

    function automatic void note_error(input string msg);
        if (err_cnt < 10) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        err_cnt++;
    endfunction

    function automatic void add_row(input logic func, input logic [SIZE_W-1:0] sz,
                                    input logic [ADDR_W-1:0] addr, input bit fixed,
                                    input logic [ADDR_W-1:0] exp_addr,
                                    input logic [1:0] exp_status);
        t_dir_row row;
        row.req.func      = func;
        row.req.req_size  = sz;
        row.req.free_addr = addr;
        row.fixed         = fixed;
        row.res.obj_addr  = exp_addr;
        row.res.status    = exp_status;
        dir_rows.push_back(row);
    endfunction

    // Results are checked first; a new item may be accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_res.size() == 0) begin
                    note_error($sformatf("result with none pending: addr %h status %0d",
                                         o_res.obj_addr, o_res.status));
                end else begin
                    oldest = pending_res.pop_front();
                    if (o_res.obj_addr !== oldest.obj_addr || o_res.status !== oldest.status)
                        note_error($sformatf(
                            "addr expected %h got %h, status expected %0d got %0d",
                            oldest.obj_addr, o_res.obj_addr, oldest.status, o_res.status));
                end
            end
            if (start && !busy) begin
                predicted = serve_request(i_req);
                if (fixed_valid) begin
                    predicted = fixed_res;
                end
                pending_res.push_back(predicted);
                status_cnt[predicted.status]++;
                item_cnt++;
                if (i_req.func == FUNC_ALLOC) begin
                    alloc_cnt++;
                end else begin
                    free_cnt++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input t_req r, input bit fixed, input t_res res);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_req       <= r;
        fixed_valid <= fixed;
        fixed_res   <= res;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain_results(input int extra);
        start <= 1'b0;
        while (pending_res.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_pool_base(input logic [ADDR_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_BASE_ADDR;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pool_base = val;
        base_cnt++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== pool_base) begin
            note_error($sformatf("pool base read back %h, expected %h", prdata, pool_base));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_res        no_res;
        logic [31:0] bases [4];
        no_res = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fixed_valid = 1'b0;
        fixed_res = '0;
        idle_pct = 0;
        err_cnt = 0;
        item_cnt = 0;
        alloc_cnt = 0;
        free_cnt = 0;
        base_cnt = 0;
        status_cnt = '{default: 0};
        pool_base = '0;
        class_cnt = 0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            class_sz[i] = '0;
            slot_map[i] = '0;
        end

        // Directed part, pool base at its reset value of zero.
        add_row(FUNC_ALLOC, 12'd0,    32'hFFFF_FFFF, 1, 32'h0,      ST_FULL);
        add_row(FUNC_FREE,  12'hFFF,  32'h0000_0000, 1, 32'h0,      ST_NOT_OWNED);
        add_row(FUNC_ALLOC, 12'd1,    32'h0,         1, 32'h0,      ST_OK);
        add_row(FUNC_ALLOC, 12'd1,    32'h0,         1, 32'h1,      ST_OK);
        add_row(FUNC_ALLOC, 12'd4095, 32'h0,         1, 32'h1000,   ST_OK);
        add_row(FUNC_ALLOC, 12'd4095, 32'h0,         1, 32'h0,      ST_FULL);
        add_row(FUNC_FREE,  12'd0,    32'h0000_1000, 1, 32'h0,      ST_OK);
        add_row(FUNC_FREE,  12'd0,    32'h0000_1000, 1, 32'h0,      ST_DOUBLE);
        add_row(FUNC_FREE,  12'd0,    32'h0000_1FFF, 1, 32'h0,      ST_NOT_OWNED);
        add_row(FUNC_FREE,  12'd0,    32'h0000_0040, 1, 32'h0,      ST_NOT_OWNED);
        add_row(FUNC_ALLOC, 12'd2048, 32'h0,         1, 32'h2000,   ST_OK);
        add_row(FUNC_ALLOC, 12'd2048, 32'h0,         1, 32'h2800,   ST_OK);
        add_row(FUNC_FREE,  12'd0,    32'h0000_2FFF, 1, 32'h0,      ST_OK);
        add_row(FUNC_ALLOC, 12'd64,   32'h0,         1, 32'h3000,   ST_OK);
        add_row(FUNC_ALLOC, 12'd63,   32'h0,         1, 32'h4000,   ST_OK);
        add_row(FUNC_ALLOC, 12'd100,  32'h0,         1, 32'h5000,   ST_OK);
        add_row(FUNC_ALLOC, 12'd7,    32'h0,         1, 32'h6000,   ST_OK);
        add_row(FUNC_ALLOC, 12'd3,    32'h0,         1, 32'h7000,   ST_OK);
        add_row(FUNC_ALLOC, 12'd5,    32'h0,         1, 32'h0,      ST_FULL);
        add_row(FUNC_FREE,  12'd0,    32'h0000_8000, 1, 32'h0,      ST_NOT_OWNED);
        add_row(FUNC_FREE,  12'd0,    32'hFFFF_FFFF, 1, 32'h0,      ST_NOT_OWNED);
        add_row(FUNC_ALLOC, 12'd1,    32'h0,         0, 32'h0,      ST_OK);
        add_row(FUNC_FREE,  12'd0,    32'h0000_0001, 0, 32'h0,      ST_OK);
        add_row(FUNC_FREE,  12'd0,    32'h0000_3FFF, 0, 32'h0,      ST_OK);
        add_row(FUNC_ALLOC, 12'd100,  32'h0,         0, 32'h0,      ST_OK);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);
        end

        // Random phases; the first base makes later class pages wrap past zero.
        bases = '{32'hFFFF_F000, 32'hFFFF_FFFF, $urandom, 32'h0000_0000};
        for (int ph = 0; ph < 4; ph++) begin
            drain_results(SETTLE_CYCLES);
            set_pool_base(bases[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case (ph)
                    0: begin
                        idle_pct = 0;
                    end
                    1: begin
                        idle_pct = 45;
                    end
                    2: begin
                        idle_pct = 29;
                    end
                    default: begin
                        idle_pct = ((n / 20) % 2 == 1) ? 45 : 0;
                    end
                endcase
                if (ph == 1 && n == PHASE_ITEMS / 2) begin
                    drain_results(0);
                end
                send_item(next_request(), 1'b0, no_res);
            end
        end

        drain_results(SETTLE_CYCLES);
        $display("Run covered %0d items (%0d allocations, %0d frees) under %0d pool bases.",
                 item_cnt, alloc_cnt, free_cnt, base_cnt);
        $display("Outcomes: ok %0d, full %0d, double free %0d, not owned %0d.",
                 status_cnt[ST_OK], status_cnt[ST_FULL], status_cnt[ST_DOUBLE],
                 status_cnt[ST_NOT_OWNED]);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still pending", pending_res.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
